// ===== design/swrs_pkg.sv =====
// ----------------------------------------------------------------------------
// swrs_pkg - shared constants and types for the sliding window rate meter
// Sizes of the sample chain, the serial divider and the register map.
// ----------------------------------------------------------------------------
package swrs_pkg;

    // sample chain
    localparam int WINDOW_MAX  = 256;
    localparam int WIN_AW      = $clog2(WINDOW_MAX);
    localparam int N_W         = WIN_AW + 1;          // holds 1..WINDOW_MAX
    localparam int SAMPLE_BITS = 48;
    localparam int FIELD_BITS  = 48;

    // counters and sums
    localparam int TOTAL_W     = 64;
    localparam int SUM_W       = 64;

    // configuration registers
    localparam int LEN_W       = 9;
    localparam int HALVES_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 2'd1;
    localparam logic [LEN_W-1:0]     WINDOW_RESET   = 9'd80;
    localparam logic [HALVES_W-1:0]  INTERVAL_RESET = 8'd3;

    // serial divider: 65-bit dividend (delta * 2), small divisor
    localparam int DIV_W       = TOTAL_W + 1;
    localparam int DIVISOR_W   = (N_W > HALVES_W) ? N_W : HALVES_W;
    localparam int DIV_CW      = $clog2(DIV_W + 1);

    // one rx/tx sample pair
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] rx;
        logic [SAMPLE_BITS-1:0] tx;
    } t_sample;

    // divider handshake
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic done;
    } t_div_stat;

endpackage

// ===== design/swrs_cell.sv =====
// ----------------------------------------------------------------------------
// swrs_cell - one slot of the sample chain
// Holds one rx/tx sample pair and a valid bit; loads its neighbor on shift.
// ----------------------------------------------------------------------------
module swrs_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_valid,
    input  swrs_pkg::t_sample i_data,
    output logic             o_valid,
    output swrs_pkg::t_sample o_data
);

    logic             r_valid;
    swrs_pkg::t_sample r_data;

    // valid bit: cleared by reset, an empty slot reads as zero downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/swrs_chain.sv =====
// ----------------------------------------------------------------------------
// swrs_chain - row of sample cells, newest sample in cell 0
// Push shifts a new pair in; rotate feeds the last cell back to the first,
// so a full lap presents every slot at the tap and restores the order.
// ----------------------------------------------------------------------------
module swrs_chain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_push,
    input  swrs_pkg::t_sample i_new,
    output swrs_pkg::t_sample o_tap
);

    logic              w_valid [swrs_pkg::WINDOW_MAX];
    swrs_pkg::t_sample w_data  [swrs_pkg::WINDOW_MAX];
    logic              w_in_valid;
    swrs_pkg::t_sample w_in_data;

    // head of the chain: new sample on push, wrap-around otherwise
    assign w_in_valid = i_push ? 1'b1 : w_valid[swrs_pkg::WINDOW_MAX-1];
    assign w_in_data  = i_push ? i_new : w_data[swrs_pkg::WINDOW_MAX-1];

    genvar g;
    generate
        for (g = 0; g < swrs_pkg::WINDOW_MAX; g++) begin : g_cell
            if (g == 0) begin : g_head
                swrs_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (i_shift),
                    .i_valid (w_in_valid),
                    .i_data  (w_in_data),
                    .o_valid (w_valid[g]),
                    .o_data  (w_data[g])
                );
            end else begin : g_body
                swrs_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (i_shift),
                    .i_valid (w_valid[g-1]),
                    .i_data  (w_data[g-1]),
                    .o_valid (w_valid[g]),
                    .o_data  (w_data[g])
                );
            end
        end
    endgenerate

    // tap at the last cell; an unwritten slot reads as zero
    assign o_tap = w_valid[swrs_pkg::WINDOW_MAX-1] ? w_data[swrs_pkg::WINDOW_MAX-1]
                                                   : '0;

endmodule

// ===== design/swrs_div.sv =====
// ----------------------------------------------------------------------------
// swrs_div - restoring divider, one quotient bit per cycle
// 65-bit dividend over a small divisor; done pulses with the quotient ready.
// ----------------------------------------------------------------------------
module swrs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  swrs_pkg::t_div_ctrl               i_ctrl,
    input  logic [swrs_pkg::DIV_W-1:0]        i_dividend,
    input  logic [swrs_pkg::DIVISOR_W-1:0]    i_divisor,
    output swrs_pkg::t_div_stat               o_stat,
    output logic [swrs_pkg::DIV_W-1:0]        o_quot
);

    logic [swrs_pkg::DIV_W-1:0]      r_quot;
    logic [swrs_pkg::DIVISOR_W-1:0]  r_rem;
    logic [swrs_pkg::DIVISOR_W-1:0]  r_divisor;
    logic [swrs_pkg::DIV_CW-1:0]     r_cnt;
    logic                            r_done;
    logic [swrs_pkg::DIVISOR_W:0]    w_part;
    logic [swrs_pkg::DIVISOR_W:0]    w_trial;
    logic                            w_fits;

    // trial subtract of the divisor from the partial remainder
    assign w_part  = {r_rem, r_quot[swrs_pkg::DIV_W-1]};
    assign w_trial = w_part - {1'b0, r_divisor};
    assign w_fits  = !w_trial[swrs_pkg::DIVISOR_W];

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_ctrl.start) begin
            r_cnt  <= swrs_pkg::DIV_CW'(swrs_pkg::DIV_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == swrs_pkg::DIV_CW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // datapath: dividend shifts out on top, quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[swrs_pkg::DIV_W-2:0], w_fits};
            r_rem  <= w_fits ? w_trial[swrs_pkg::DIVISOR_W-1:0]
                             : w_part[swrs_pkg::DIVISOR_W-1:0];
        end
    end

    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

// ===== design/sliding_window_rate_stats_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_stats_top - byte-rate meter with a sliding window
// Polled rx/tx byte totals in; newest rates, window average and peak out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one poll beat: tdata = {tx_total, rx_total}.
//   m_axis returns one result beat per poll: tuser = valid_res, tdata holds
//   the six 48-bit rate fields. cfg writes window_len (index 0) and
//   interval_halves (index 1); write them only while the block is idle.
//   A poll taken while either stored total is zero is a baseline beat:
//   valid_res = 0, all fields 0; its result is posted straight from idle.
//   Otherwise the poll runs the serial rate divide, pushes the sample, walks
//   the cell chain once around (sum and max), loads and runs the average
//   divide and posts the result. Most of the time per poll goes to the
//   256-cell walk and the two bit-serial divides; one poll is in flight at
//   a time, and the next is taken once the result is posted.
//   The result sits in an output register, so the next poll is accepted
//   while a stalled result waits; only posting the following result waits
//   for m_axis_tready.
//   Reset clears the stored totals, every sample slot (through per-cell
//   valid bits) and restores window_len = 80, interval_halves = 3; neither
//   input channel is ready while reset is held.
// ----------------------------------------------------------------------------
module sliding_window_rate_stats_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // poll input; tdata: rx_total [63:0], tx_total [127:64]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [2*swrs_pkg::TOTAL_W-1:0]      s_axis_tdata,
    // result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: rx_rate, tx_rate, rx_avg, tx_avg, rx_peak, tx_peak (48 each)
    output logic [6*swrs_pkg::FIELD_BITS-1:0]   m_axis_tdata,
    // tuser: valid_res [0]
    output logic                                m_axis_tuser,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [swrs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_RATE     = 7'b0000010,
        S_PUSH     = 7'b0000100,
        S_WALK     = 7'b0001000,
        S_AVG_GO   = 7'b0010000,
        S_AVG_WAIT = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    localparam int FB = swrs_pkg::FIELD_BITS;
    localparam int SB = swrs_pkg::SAMPLE_BITS;
    localparam int TW = swrs_pkg::TOTAL_W;

    t_state r_state, n_state;

    logic [swrs_pkg::LEN_W-1:0]    r_window_len;
    logic [swrs_pkg::HALVES_W-1:0] r_interval;
    logic [TW-1:0]                 r_prev_rx;
    logic [TW-1:0]                 r_prev_tx;
    logic [swrs_pkg::N_W-1:0]      r_n;
    logic [swrs_pkg::WIN_AW-1:0]   r_walk_cnt;
    logic [swrs_pkg::SUM_W-1:0]    r_sum_rx;
    logic [swrs_pkg::SUM_W-1:0]    r_sum_tx;
    logic [SB-1:0]                 r_max_rx;
    logic [SB-1:0]                 r_max_tx;
    swrs_pkg::t_sample             r_rate;
    logic [FB-1:0]                 r_avg_rx;
    logic [FB-1:0]                 r_avg_tx;
    logic                          r_res_valid;
    logic                          r_out_valid;
    logic [6*FB-1:0]               r_out_data;
    logic                          r_out_user;

    logic                          w_in_beat;
    logic                          w_cfg_beat;
    logic                          w_live;
    logic                          w_start_rate;
    logic [TW-1:0]                 w_delta_rx;
    logic [TW-1:0]                 w_delta_tx;
    logic [swrs_pkg::N_W-1:0]      w_n;
    logic [swrs_pkg::HALVES_W-1:0] w_h;
    swrs_pkg::t_div_ctrl           w_div_ctrl;
    logic [swrs_pkg::DIV_W-1:0]    w_dvd_rx;
    logic [swrs_pkg::DIV_W-1:0]    w_dvd_tx;
    logic [swrs_pkg::DIVISOR_W-1:0] w_dvs;
    swrs_pkg::t_div_stat           w_stat_rx;
    swrs_pkg::t_div_stat           w_stat_tx;
    logic                          w_div_done;
    logic [swrs_pkg::DIV_W-1:0]    w_quot_rx;
    logic [swrs_pkg::DIV_W-1:0]    w_quot_tx;
    swrs_pkg::t_sample             w_sat;
    swrs_pkg::t_sample             w_tap;
    logic                          w_shift;
    logic                          w_push;
    logic [swrs_pkg::N_W:0]        w_incl_sum;
    logic                          w_incl;
    logic                          w_post;

    // handshakes
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_cfg_ready   = i_rst_n;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_cfg_beat    = i_cfg_valid && o_cfg_ready;
    assign w_live        = (r_prev_rx != '0) && (r_prev_tx != '0);
    assign w_start_rate  = w_in_beat && w_live;
    assign w_post        = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= swrs_pkg::WINDOW_RESET;
            r_interval   <= swrs_pkg::INTERVAL_RESET;
        end else if (w_cfg_beat) begin
            case (i_cfg_index)
                swrs_pkg::CFG_WINDOW_LEN: r_window_len <= i_cfg_data[swrs_pkg::LEN_W-1:0];
                swrs_pkg::CFG_INTERVAL:   r_interval   <= i_cfg_data[swrs_pkg::HALVES_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp window length and interval
    always_comb begin
        if (r_window_len == '0) begin
            w_n = swrs_pkg::N_W'(1);
        end else if (r_window_len > swrs_pkg::LEN_W'(swrs_pkg::WINDOW_MAX)) begin
            w_n = swrs_pkg::N_W'(swrs_pkg::WINDOW_MAX);
        end else begin
            w_n = swrs_pkg::N_W'(r_window_len);
        end
    end
    assign w_h = (r_interval == '0) ? swrs_pkg::HALVES_W'(1) : r_interval;

    // deltas mod 2^64
    assign w_delta_rx = s_axis_tdata[TW-1:0]    - r_prev_rx;
    assign w_delta_tx = s_axis_tdata[2*TW-1:TW] - r_prev_tx;

    // stored totals, always updated on a poll beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rx <= '0;
            r_prev_tx <= '0;
        end else if (w_in_beat) begin
            r_prev_rx <= s_axis_tdata[TW-1:0];
            r_prev_tx <= s_axis_tdata[2*TW-1:TW];
        end
    end

    // divider operands: delta*2 over interval, then window sum over length
    assign w_div_ctrl.start = w_start_rate || (r_state == S_AVG_GO);
    assign w_dvd_rx = (r_state == S_AVG_GO) ? swrs_pkg::DIV_W'(r_sum_rx) : {w_delta_rx, 1'b0};
    assign w_dvd_tx = (r_state == S_AVG_GO) ? swrs_pkg::DIV_W'(r_sum_tx) : {w_delta_tx, 1'b0};
    assign w_dvs    = (r_state == S_AVG_GO) ? swrs_pkg::DIVISOR_W'(r_n)
                                            : swrs_pkg::DIVISOR_W'(w_h);

    swrs_div u_div_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_dvd_rx),
        .i_divisor  (w_dvs),
        .o_stat     (w_stat_rx),
        .o_quot     (w_quot_rx)
    );

    swrs_div u_div_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_dvd_tx),
        .i_divisor  (w_dvs),
        .o_stat     (w_stat_tx),
        .o_quot     (w_quot_tx)
    );

    // both dividers run in lockstep
    assign w_div_done = w_stat_rx.done && w_stat_tx.done;

    // rate saturation at the sample width
    assign w_sat.rx = (w_quot_rx[swrs_pkg::DIV_W-1:SB] != '0) ? {SB{1'b1}} : w_quot_rx[SB-1:0];
    assign w_sat.tx = (w_quot_tx[swrs_pkg::DIV_W-1:SB] != '0) ? {SB{1'b1}} : w_quot_tx[SB-1:0];

    // sample chain: push once, then one full lap for the walk
    assign w_push  = (r_state == S_PUSH);
    assign w_shift = w_push || (r_state == S_WALK);

    swrs_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_shift),
        .i_push  (w_push),
        .i_new   (r_rate),
        .o_tap   (w_tap)
    );

    // at lap step k the tap holds slot WINDOW_MAX-1-k; keep slots below n
    assign w_incl_sum = {1'b0, 1'b0, r_walk_cnt} + {1'b0, r_n};
    assign w_incl     = (w_incl_sum >= (swrs_pkg::N_W+1)'(swrs_pkg::WINDOW_MAX));

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_in_beat) n_state = w_live ? S_RATE : S_DONE;
            S_RATE:     if (w_div_done) n_state = S_PUSH;
            S_PUSH:     n_state = S_WALK;
            S_WALK:     if (r_walk_cnt == '1) n_state = S_AVG_GO;
            S_AVG_GO:   n_state = S_AVG_WAIT;
            S_AVG_WAIT: if (w_div_done) n_state = S_DONE;
            S_DONE:     if (w_post) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_n         <= w_n;
            r_res_valid <= w_live;
            r_rate      <= '0;
            r_avg_rx    <= '0;
            r_avg_tx    <= '0;
            r_max_rx    <= '0;
            r_max_tx    <= '0;
        end
        if ((r_state == S_RATE) && w_div_done) begin
            r_rate <= w_sat;
        end
        if (w_push) begin
            r_walk_cnt <= '0;
            r_sum_rx   <= '0;
            r_sum_tx   <= '0;
            r_max_rx   <= '0;
            r_max_tx   <= '0;
        end
        // window walk: sum and max over included slots
        if (r_state == S_WALK) begin
            r_walk_cnt <= r_walk_cnt + 1'b1;
            if (w_incl) begin
                r_sum_rx <= r_sum_rx + swrs_pkg::SUM_W'(w_tap.rx);
                r_sum_tx <= r_sum_tx + swrs_pkg::SUM_W'(w_tap.tx);
                if (w_tap.rx > r_max_rx) r_max_rx <= w_tap.rx;
                if (w_tap.tx > r_max_tx) r_max_tx <= w_tap.tx;
            end
        end
        if ((r_state == S_AVG_WAIT) && w_div_done) begin
            r_avg_rx <= w_quot_rx[FB-1:0];
            r_avg_tx <= w_quot_tx[FB-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_post) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_post) begin
            r_out_user <= r_res_valid;
            r_out_data <= {FB'(r_max_tx), FB'(r_max_rx), r_avg_tx, r_avg_rx,
                           FB'(r_rate.tx), FB'(r_rate.rx)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== tb/sv/sliding_window_rate_stats_top_test.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_stats_top_test - self-checking bench for the rate meter
// Drives polled rx/tx byte totals and register writes into the meter, then
// checks every result beat against a model of the sliding window kept here.
// A short table of directed polls comes first, followed by random phases,
// each under a new window length and poll interval.
// ----------------------------------------------------------------------------
module sliding_window_rate_stats_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swrs_pkg::*;

    localparam int             CLK_HALF      = 10;
    localparam int             CYCLE_LIMIT   = 12_000_000;
    localparam int             PHASES        = 10;
    localparam int             POLLS_PER_PH  = 190;
    localparam int             DRAIN_CYCLES  = 400;
    localparam logic [47:0]    RATE_SAT      = '1;
    localparam logic [8:0]     LEN_AT_RESET  = 9'd80;
    localparam logic [7:0]     HALF_AT_RESET = 8'd3;

    // one result beat: valid_res plus the six rate fields, rx_rate first
    typedef struct packed {
        logic             valid;
        logic [5:0][47:0] field;
    } stats_t;

    typedef enum logic {ROW_CFG, ROW_POLL} row_kind_e;

    typedef struct {
        row_kind_e               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [TOTAL_W-1:0]      rx;
        logic [TOTAL_W-1:0]      tx;
        bit                      typed;
        stats_t                  want;
    } plan_row_t;

    // DUT ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [2*TOTAL_W-1:0]          s_axis_tdata = '0;    // rx_total, tx_total
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [6*FIELD_BITS-1:0]       m_axis_tdata;         // rates, avgs, peaks
    logic                          m_axis_tuser;         // valid_res
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    // meter model state
    logic [8:0]                    cur_len = LEN_AT_RESET;
    logic [7:0]                    cur_halves = HALF_AT_RESET;
    logic [TOTAL_W-1:0]            held_rx = '0;
    logic [TOTAL_W-1:0]            held_tx = '0;
    logic [47:0]                   rx_hist [WINDOW_MAX] = '{default: '0};
    logic [47:0]                   tx_hist [WINDOW_MAX] = '{default: '0};

    stats_t                        pending_stats [$];
    plan_row_t                     test_plan [$];
    int                            mismatches = 0;
    int                            results_seen = 0;
    int                            cycles = 0;
    bit                            idle_on = 1'b1;
    string                         field_name [6] = '{"rx_rate", "tx_rate", "rx_avg",
                                                      "tx_avg", "rx_peak", "tx_peak"};

    sliding_window_rate_stats_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // rate = floor(2 * delta / halves), clipped to the sample width
    function automatic logic [47:0] rate_from_delta(logic [63:0] delta, logic [7:0] halves);
        logic [64:0] q;
        q = {delta, 1'b0} / {57'd0, halves};
        return (q > {17'd0, RATE_SAT}) ? RATE_SAT : q[47:0];
    endfunction

    // advance the meter by one poll and return the beat it should produce
    function automatic stats_t rate_window_step(logic [63:0] rx, logic [63:0] tx);
        stats_t      s;
        int          n;
        logic [7:0]  h;
        logic [63:0] rsum;
        logic [63:0] tsum;
        logic [47:0] rpk;
        logic [47:0] tpk;
        s = '0;
        if (held_rx != 0 && held_tx != 0) begin
            n = (cur_len == 0) ? 1 : (cur_len > WINDOW_MAX) ? WINDOW_MAX : int'(cur_len);
            h = (cur_halves == 0) ? 8'd1 : cur_halves;
            for (int i = WINDOW_MAX - 1; i > 0; i--) begin
                rx_hist[i] = rx_hist[i-1];
                tx_hist[i] = tx_hist[i-1];
            end
            rx_hist[0] = rate_from_delta(rx - held_rx, h);
            tx_hist[0] = rate_from_delta(tx - held_tx, h);
            rsum = '0;
            tsum = '0;
            rpk  = '0;
            tpk  = '0;
            for (int i = 0; i < n; i++) begin
                rsum += {16'd0, rx_hist[i]};
                tsum += {16'd0, tx_hist[i]};
                if (rx_hist[i] > rpk) rpk = rx_hist[i];
                if (tx_hist[i] > tpk) tpk = tx_hist[i];
            end
            s.valid    = 1'b1;
            s.field[0] = rx_hist[0];
            s.field[1] = tx_hist[0];
            s.field[2] = 48'(rsum / 64'(n));
            s.field[3] = 48'(tsum / 64'(n));
            s.field[4] = rpk;
            s.field[5] = tpk;
        end
        held_rx = rx;
        held_tx = tx;
        return s;
    endfunction

    function automatic stats_t known_stats(logic v, logic [47:0] rr, logic [47:0] tr,
                                           logic [47:0] ra, logic [47:0] ta,
                                           logic [47:0] rp, logic [47:0] tp);
        stats_t s;
        s.valid    = v;
        s.field[0] = rr;
        s.field[1] = tr;
        s.field[2] = ra;
        s.field[3] = ta;
        s.field[4] = rp;
        s.field[5] = tp;
        return s;
    endfunction

    function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.rx    = '0;
        r.tx    = '0;
        r.typed = 1'b0;
        r.want  = '0;
        test_plan.push_back(r);
    endfunction

    function automatic void plan_poll(logic [63:0] rx, logic [63:0] tx,
                                      bit typed = 1'b0, stats_t want = '0);
        plan_row_t r;
        r.kind  = ROW_POLL;
        r.idx   = '0;
        r.data  = '0;
        r.rx    = rx;
        r.tx    = tx;
        r.typed = typed;
        r.want  = want;
        test_plan.push_back(r);
    endfunction

    // byte delta for one counter: mostly small or mid-sized, some near clipping
    function automatic logic [63:0] draw_delta(logic [7:0] halves);
        logic [63:0] wide;
        logic [63:0] edge_pt;
        wide    = {$urandom, $urandom};
        edge_pt = {55'd0, (halves == 0) ? 8'd1 : halves, 1'b0} << 46;
        case ($urandom_range(9))
            0:       return '0;
            1, 2, 3: return 64'($urandom_range(4095));
            4, 5, 6: return wide >> $urandom_range(63);
            7:       return edge_pt - 64'($urandom_range(2)) + 64'($urandom_range(2));
            8:       return wide >> $urandom_range(24, 8);
            default: return wide;
        endcase
    endfunction

    task automatic log_mismatch(string msg);
        $display("%0t ns: result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    // poll beat; tvalid stays up after the handshake unless a gap follows
    task automatic send_poll(logic [63:0] rx, logic [63:0] tx, bit typed, stats_t want);
        int     gap;
        stats_t s;
        gap = 0;
        if (idle_on) begin
            if ($urandom_range(15) == 0) gap = $urandom_range(500, 1);
            else while ($urandom_range(99) < 8) gap++;
        end
        i_cfg_valid <= 1'b0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tx, rx};
        do @(posedge i_clk); while (!s_axis_tready);
        s = rate_window_step(rx, tx);
        pending_stats.push_back(typed ? want : s);
    endtask

    // register write, only once every pending result has come back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WINDOW_LEN: cur_len = data;
            CFG_INTERVAL:   cur_halves = data[7:0];
            default:        ;
        endcase
    endtask

    // result side backpressure: short random stalls, now and then a long one
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(999) == 0) begin
                stall_left = $urandom_range(500, 20);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(99) < 8);
            end
        end
    end

    // compare each result beat with the oldest pending one
    always @(posedge i_clk) begin : result_check
        stats_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_stats.size() == 0) begin
                log_mismatch("result beat with nothing pending");
            end else begin
                want = pending_stats.pop_front();
                if (m_axis_tuser !== want.valid)
                    log_mismatch($sformatf("valid_res got %b want %b", m_axis_tuser,
                                           want.valid));
                for (int k = 0; k < 6; k++) begin
                    if (m_axis_tdata[k*FIELD_BITS +: FIELD_BITS] !== want.field[k])
                        log_mismatch($sformatf("%s got %h want %h", field_name[k],
                                               m_axis_tdata[k*FIELD_BITS +: FIELD_BITS],
                                               want.field[k]));
                end
            end
            results_seen++;
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        logic [63:0]           nrx;
        logic [63:0]           ntx;
        logic [CFG_DATA_W-1:0] len_val;
        logic [CFG_DATA_W-1:0] half_val;
        int                    r;

        // first poll after reset only sets the baseline
        plan_poll(64'd1000, 64'd2000, 1'b1, known_stats(0, 0, 0, 0, 0, 0, 0));
        plan_poll(64'd1768, 64'd3536);
        plan_poll(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_cfg(CFG_WINDOW_LEN, 9'd1);
        plan_cfg(CFG_INTERVAL, 9'd1);
        // both counters wrap through zero
        plan_poll(64'd1, 64'd2, 1'b1, known_stats(1, 4, 6, 4, 6, 4, 6));
        // rx delta of all ones clips; tx lands one step under the clip
        plan_poll(64'd0, 64'h0000_8000_0000_0001, 1'b1,
                  known_stats(1, RATE_SAT, RATE_SAT - 1, RATE_SAT, RATE_SAT - 1,
                              RATE_SAT, RATE_SAT - 1));
        // stored rx is zero: baseline, store untouched
        plan_poll(64'd500, 64'h0000_8000_0000_0000, 1'b1, known_stats(0, 0, 0, 0, 0, 0, 0));
        // zero delta still counts; tx delta hits exactly one past the clip
        plan_poll(64'd500, 64'h0001_0000_0000_0000, 1'b1,
                  known_stats(1, 0, RATE_SAT, 0, RATE_SAT, 0, RATE_SAT));
        // zero window and zero interval both act as one
        plan_cfg(CFG_WINDOW_LEN, 9'd0);
        plan_cfg(CFG_INTERVAL, 9'd0);
        plan_poll(64'd507, 64'h0001_0000_0000_000A, 1'b1, known_stats(1, 14, 20, 14, 20, 14, 20));
        // oversize window clips to the full store
        plan_cfg(CFG_WINDOW_LEN, 9'h1FF);
        plan_cfg(CFG_INTERVAL, 9'd255);
        plan_poll(64'd255507, 64'h0001_0000_0000_03F2);
        plan_poll(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        plan_poll(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        // top data bit is not part of the interval
        plan_cfg(CFG_WINDOW_LEN, 9'd2);
        plan_cfg(CFG_INTERVAL, 9'h103);
        plan_poll(64'hAAAA_AAAA_AAAA_ABD6, 64'h5555_5555_5555_555C);
        plan_poll(64'hAAAA_AAAA_AAAB_0000, 64'h5555_5555_5556_0000);
        plan_poll(64'hAAAA_AAAA_AAAB_0001, 64'h5555_5555_5556_0001);
        // window grows back: older samples return
        plan_cfg(CFG_WINDOW_LEN, 9'd256);
        plan_cfg(CFG_INTERVAL, 9'h100);
        plan_poll(64'hAAAA_AAAA_AAAB_1001, 64'h5555_5555_5556_2001);
        plan_cfg(CFG_WINDOW_LEN, 9'd3);
        plan_cfg(CFG_INTERVAL, 9'd255);
        plan_poll(64'hAAAA_AAAA_AABB_1001, 64'd0);
        plan_poll(64'hAAAA_AAAA_AABB_2001, 64'd7, 1'b1, known_stats(0, 0, 0, 0, 0, 0, 0));
        plan_poll(64'hAAAA_AAAA_AABB_3001, 64'd9000);
        plan_cfg(CFG_WINDOW_LEN, 9'd257);
        plan_cfg(CFG_INTERVAL, 9'd3);
        plan_poll(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (test_plan[i]) begin
            if (test_plan[i].kind == ROW_CFG)
                write_reg(test_plan[i].idx, test_plan[i].data);
            else
                send_poll(test_plan[i].rx, test_plan[i].tx, test_plan[i].typed,
                          test_plan[i].want);
        end

        // random phases, each with its own window and interval
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(7))
                0:       len_val = 9'd1;
                1:       len_val = 9'd2;
                2:       len_val = 9'd256;
                3:       len_val = 9'($urandom_range(511, 257));
                4:       len_val = 9'd0;
                5:       len_val = 9'($urandom_range(16, 3));
                default: len_val = 9'($urandom_range(256, 1));
            endcase
            case ($urandom_range(5))
                0:       half_val = 9'd1;
                1:       half_val = 9'd255;
                2:       half_val = 9'd0;
                3:       half_val = 9'd3;
                default: half_val = {1'($urandom_range(1)), 8'($urandom_range(255, 1))};
            endcase
            write_reg(CFG_WINDOW_LEN, len_val);
            write_reg(CFG_INTERVAL, half_val);
            idle_on = (p != 5);
            for (int i = 0; i < POLLS_PER_PH; i++) begin
                r   = $urandom_range(99);
                nrx = held_rx + draw_delta(cur_halves);
                ntx = held_tx + draw_delta(cur_halves);
                if (r < 2) nrx = '0;
                else if (r < 4) ntx = '0;
                else if (r < 8) begin
                    nrx = {$urandom, $urandom};
                    ntx = {$urandom, $urandom};
                end else if (r < 10) begin
                    nrx = ~64'($urandom_range(4095));
                end
                send_poll(nrx, ntx, 1'b0, '0);
            end
        end
        idle_on = 1'b1;

        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/swrs_pkg.sv
design/swrs_cell.sv
design/swrs_chain.sv
design/swrs_div.sv
design/sliding_window_rate_stats_top.sv
tb/sv/sliding_window_rate_stats_top_test.sv
